FILE: sv/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

    // Store geometry.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Configuration port geometry.
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int CAP_W       = 5;
    localparam int REG_IDX_W   = 1;
    localparam int CAP_RESET   = 16;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_kind_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

FILE: sv/sle_cfg.sv
`timescale 1ns / 1ps

module sle_cfg
    import sle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CAP_W-1:0]   capacity
);

    logic [CAP_W-1:0]     capacity_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Registers sit on word boundaries; the index comes from the word address.
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(CAP_RESET);
        end
        else if (wr_en && (reg_idx == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read-back of the register file.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_CAPACITY)
        begin
            prdata = PDATA_W'(capacity_reg);
        end
    end

    assign capacity = capacity_reg;

endmodule

FILE: sv/sle_ctrl.sv
`timescale 1ns / 1ps

module sle_ctrl
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a new transaction may be taken while the last result is shown.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            ST_DONE:
            begin
                done     = 1'b1;
                cmd.load = start;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/sle_datapath.sv
`timescale 1ns / 1ps

module sle_datapath
    import sle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    input  logic [1:0]            kind,
    input  logic [ADDR_W-1:0]     position,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [CAP_W-1:0]      capacity,
    output logic                  ok,
    output logic [DATA_WIDTH-1:0] read_value,
    output logic [CNT_W-1:0]      list_length
);

    op_kind_t              kind_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    logic [DATA_WIDTH-1:0] entries_reg  [DEPTH];
    logic [DATA_WIDTH-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic                  ok_reg;
    logic                  ok_next;
    logic [DATA_WIDTH-1:0] rd_reg;
    logic [DATA_WIDTH-1:0] rd_next;

    logic [CNT_W-1:0]      eff_cap;
    logic                  pos_valid;
    logic                  has_room;

    // Operand registers, loaded when a transaction is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= op_kind_t'(kind);
            pos_reg  <= position;
            val_reg  <= value;
        end
    end

    // Capacity saturates at the store depth.
    always_comb
    begin
        if (CNT_W'(capacity) > CNT_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(capacity);
        end
    end

    assign pos_valid = CNT_W'(pos_reg) < count_reg;
    assign has_room  = count_reg < eff_cap;

    // Operation decode and the shifting register row.
    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        ok_next      = 1'b0;
        rd_next      = '0;
        if (cmd.exec)
        begin
            case (kind_reg)
                OP_APPEND:
                begin
                    if (has_room)
                    begin
                        entries_next[count_reg[ADDR_W-1:0]] = val_reg;
                        count_next = count_reg + CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (pos_valid)
                    begin
                        // Each slot from the position up to the tail takes its upper neighbor.
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            if ((ADDR_W'(i) >= pos_reg) && (CNT_W'(i + 1) < count_reg))
                            begin
                                entries_next[i] = entries_reg[i + 1];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (pos_valid)
                    begin
                        rd_next = entries_reg[pos_reg];
                        ok_next = 1'b1;
                    end
                end
                default:
                begin
                    if (pos_valid)
                    begin
                        entries_next[pos_reg] = val_reg;
                        ok_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // Entry store: contents are defined only once written.
    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    // Length counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result register, updated by the execute step.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg <= ok_next;
            rd_reg <= rd_next;
        end
    end

    assign ok          = ok_reg;
    assign read_value  = rd_reg;
    assign list_length = count_reg;

endmodule

FILE: sv/sequential_list_engine_unit.sv
`timescale 1ns / 1ps

// Bounded ordered list of up to 16 words with append, delete-at-position, read and
// write. An operation is taken at a clock edge where start is high and busy is low;
// busy is high for the single execute cycle that follows, and in the next cycle done
// pulses for exactly one cycle with ok, read_value and list_length, which must be
// captured then because the result cannot be held off. A new operation may be
// issued while done is high, so the next operation follows as soon as the last
// result, set by the controller's execute step and the result register behind it, is shown.
// Delete compacts the whole list in the execute step through a shifting register row.
// The capacity register at byte address 0 resets to 16 and should be written only
// while no operation is in flight.
module sequential_list_engine_unit
    import sle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            kind,
    input  logic [ADDR_W-1:0]     position,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  done,
    output logic                  ok,
    output logic [DATA_WIDTH-1:0] read_value,
    output logic [CNT_W-1:0]      list_length,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    ctrl_cmd_t        cmd;
    logic [CAP_W-1:0] capacity;

    // Configuration registers.
    sle_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // Transaction sequencer.
    sle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // List store and result logic.
    sle_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .position    (position),
        .value       (value),
        .capacity    (capacity),
        .ok          (ok),
        .read_value  (read_value),
        .list_length (list_length)
    );

    // Every execute cycle is followed by exactly one result strobe.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> done)
        else $error("execute cycle not followed by a result");

    // A result strobe only follows an execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without an execute cycle");

    // A failed operation never returns read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_value == '0))
        else $error("failed operation returned nonzero read data");

    // The length never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (list_length <= CNT_W'(DEPTH)))
        else $error("list length beyond store depth");

endmodule
